// File: design/rkc_pkg.sv
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types, codes and defaults of the RGB kernel convolution unit.
// ----------------------------------------------------------------------------
package rkc_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_MAX_KERNEL = 7;

    localparam logic [7:0] PIX_MAX = 8'd255;

    // input op codes
    localparam logic [1:0] OP_PIX  = 2'd0;
    localparam logic [1:0] OP_COEF = 2'd1;
    localparam logic [1:0] OP_CONV = 2'd2;

    // register indexes and port width
    localparam int         ADDR_W    = 5;
    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KSIZE = 3'd2;
    localparam logic [2:0] REG_GAIN  = 3'd3;
    localparam logic [2:0] REG_BIAS  = 3'd4;

    localparam logic [7:0]  RST_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_HEIGHT = 8'd128;
    localparam logic [2:0]  RST_KSIZE  = 3'd3;
    localparam logic [15:0] RST_GAIN   = 16'd4096;
    localparam logic [15:0] RST_BIAS   = 16'd0;

    typedef struct packed {
        logic [1:0]         op;
        logic [6:0]         x;
        logic [6:0]         y;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  width;
        logic [7:0]  height;
        logic [2:0]  ksize;
        logic [15:0] gain;
        logic [15:0] bias;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_PIX,
        CMD_COEF,
        CMD_CONV
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [6:0]         x;
        logic [6:0]         y;
        logic [23:0]        rgb;
        logic [5:0]         ci;
        logic signed [15:0] cv;
    } t_cmd;

endpackage

// File: design/rkc_front.sv
// ----------------------------------------------------------------------------
// rkc_front
// Accepts items, drops those with no effect, queues commands for the back end.
// ----------------------------------------------------------------------------
module rkc_front #(
    parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rkc_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_stall,
    input  rkc_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output rkc_pkg::t_cmd     o_cmd,
    input  logic              i_pop
);

    rkc_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp;
    logic          n_rp;
    logic [1:0]    n_cnt;

    logic [8:0]    w_eff;
    logic [8:0]    h_eff;
    logic          keep;
    logic          push;
    logic          pop;
    rkc_pkg::t_cmd cmd;

    always_comb begin
        if (i_cfg.width == 8'd0) begin
            w_eff = 9'd1;
        end else if (int'(i_cfg.width) > MAX_WIDTH) begin
            w_eff = 9'(MAX_WIDTH);
        end else begin
            w_eff = 9'(i_cfg.width);
        end
        if (i_cfg.height == 8'd0) begin
            h_eff = 9'd1;
        end else if (int'(i_cfg.height) > MAX_HEIGHT) begin
            h_eff = 9'(MAX_HEIGHT);
        end else begin
            h_eff = 9'(i_cfg.height);
        end
    end

    // classify: pixel writes off the image, bad tap indexes and op 3 vanish
    always_comb begin
        cmd.x   = i_item.x;
        cmd.y   = i_item.y;
        cmd.rgb = {i_item.red_in, i_item.green_in, i_item.blue_in};
        cmd.ci  = i_item.coef_index;
        cmd.cv  = i_item.coef_value;
        case (i_item.op)
            rkc_pkg::OP_PIX: begin
                cmd.kind = rkc_pkg::CMD_PIX;
                keep     = (9'(i_item.x) < w_eff) && (9'(i_item.y) < h_eff);
            end
            rkc_pkg::OP_COEF: begin
                cmd.kind = rkc_pkg::CMD_COEF;
                keep     = int'(i_item.coef_index) < MAX_KERNEL * MAX_KERNEL;
            end
            rkc_pkg::OP_CONV: begin
                cmd.kind = rkc_pkg::CMD_CONV;
                keep     = 1'b1;
            end
            default: begin
                cmd.kind = rkc_pkg::CMD_CONV;
                keep     = 1'b0;
            end
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// File: design/rkc_back.sv
// ----------------------------------------------------------------------------
// rkc_back
// Executes queued commands: store writes and the tap-serial convolution.
// ----------------------------------------------------------------------------
module rkc_back #(
    parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rkc_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  rkc_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output rkc_pkg::t_out_item o_item
);

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int NC   = MAX_KERNEL * MAX_KERNEL;
    localparam int CIW  = (NC > 1) ? $clog2(NC) : 1;
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int DIM0 = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM  = (DIM0 > 256) ? DIM0 : 256;
    localparam int CW   = $clog2(DIM) + 2;
    localparam int SW   = 25 + $clog2(NC);
    localparam int MW   = SW + 16;
    localparam int TW   = MW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TAP   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_SCALE = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]        w_eff;
    logic [CW-1:0]        h_eff;
    logic [KW-1:0]        ks_eff;
    logic [KW-1:0]        half;

    logic signed [CW-1:0] r_ix;
    logic signed [CW-1:0] r_iy;
    logic signed [CW-1:0] r_ix0;
    logic [KW-1:0]        r_fx;
    logic [KW-1:0]        r_fy;
    logic [CIW-1:0]       r_ci;
    logic [CW-1:0]        ixc;
    logic [CW-1:0]        iyc;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;

    logic [23:0]          r_fmem [NPIX];
    logic signed [15:0]   r_cmem [NC];
    logic [23:0]          r_pix;
    logic signed [15:0]   r_coef;
    logic                 r_v1;
    logic                 r_v2;
    logic signed [24:0]   r_pr;
    logic signed [24:0]   r_pg;
    logic signed [24:0]   r_pb;
    logic signed [SW-1:0] r_sr;
    logic signed [SW-1:0] r_sg;
    logic signed [SW-1:0] r_sb;
    logic signed [MW-1:0] r_mr;
    logic signed [MW-1:0] r_mg;
    logic signed [MW-1:0] r_mb;
    rkc_pkg::t_out_item   r_out;

    logic                 pop;
    logic                 fwe;
    logic                 cwe;
    logic                 start;
    logic                 row_end;
    logic                 last_tap;
    logic signed [TW-1:0] bias_q;

    function automatic logic [7:0] sat_pix(input logic signed [TW-1:0] t);
        logic [7:0] r;
        if (t[TW-1]) begin
            r = 8'd0;
        end else if (|t[TW-2:28]) begin
            r = rkc_pkg::PIX_MAX;
        end else begin
            r = t[27:20];
        end
        return r;
    endfunction

    always_comb begin
        if (i_cfg.width == 8'd0) begin
            w_eff = CW'(1);
        end else if (int'(i_cfg.width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(i_cfg.width);
        end
        if (i_cfg.height == 8'd0) begin
            h_eff = CW'(1);
        end else if (int'(i_cfg.height) > MAX_HEIGHT) begin
            h_eff = CW'(MAX_HEIGHT);
        end else begin
            h_eff = CW'(i_cfg.height);
        end
        if (int'(i_cfg.ksize) > MAX_KERNEL) begin
            ks_eff = KW'(MAX_KERNEL);
        end else begin
            ks_eff = KW'(i_cfg.ksize);
        end
        half = ks_eff >> 1;
    end

    // clamp-to-edge tap coordinates
    always_comb begin
        if (r_ix < 0) begin
            ixc = '0;
        end else if ($unsigned(r_ix) >= w_eff) begin
            ixc = w_eff - CW'(1);
        end else begin
            ixc = $unsigned(r_ix);
        end
        if (r_iy < 0) begin
            iyc = '0;
        end else if ($unsigned(r_iy) >= h_eff) begin
            iyc = h_eff - CW'(1);
        end else begin
            iyc = $unsigned(r_iy);
        end
        rd_addr = AW'(ixc) + AW'(iyc) * AW'(MAX_WIDTH);
        wr_addr = AW'(i_cmd.x) + AW'(i_cmd.y) * AW'(MAX_WIDTH);
    end

    assign pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_pop    = pop;
    assign fwe      = pop && (i_cmd.kind == rkc_pkg::CMD_PIX);
    assign cwe      = pop && (i_cmd.kind == rkc_pkg::CMD_COEF);
    assign start    = pop && (i_cmd.kind == rkc_pkg::CMD_CONV);
    assign row_end  = (r_fx == ks_eff - KW'(1));
    assign last_tap = row_end && (r_fy == ks_eff - KW'(1));
    assign bias_q   = TW'($signed(i_cfg.bias)) <<< 16;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (ks_eff == '0) ? S_SCALE : S_TAP;
                end
            end
            S_TAP: begin
                if (last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_TAP);
            r_v2    <= r_v1;
        end
    end

    // tap walk
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_ix  <= $signed(CW'(i_cmd.x)) - $signed(CW'(half));
            r_ix0 <= $signed(CW'(i_cmd.x)) - $signed(CW'(half));
            r_iy  <= $signed(CW'(i_cmd.y)) - $signed(CW'(half));
            r_fx  <= '0;
            r_fy  <= '0;
            r_ci  <= '0;
        end else if (r_state == S_TAP) begin
            r_ci <= r_ci + CIW'(1);
            if (row_end) begin
                r_fx <= '0;
                r_ix <= r_ix0;
                r_fy <= r_fy + KW'(1);
                r_iy <= r_iy + CW'(1);
            end else begin
                r_fx <= r_fx + KW'(1);
                r_ix <= r_ix + CW'(1);
            end
        end
    end

    // frame store, registered read
    always_ff @(posedge i_clk) begin
        if (fwe) begin
            r_fmem[wr_addr] <= i_cmd.rgb;
        end
        r_pix <= r_fmem[rd_addr];
    end

    // coefficient store, registered read
    always_ff @(posedge i_clk) begin
        if (cwe) begin
            r_cmem[CIW'(i_cmd.ci)] <= i_cmd.cv;
        end
        r_coef <= r_cmem[r_ci];
    end

    // multiply, accumulate, scale, finish
    always_ff @(posedge i_clk) begin
        r_pr <= $signed({1'b0, r_pix[23:16]}) * r_coef;
        r_pg <= $signed({1'b0, r_pix[15:8]}) * r_coef;
        r_pb <= $signed({1'b0, r_pix[7:0]}) * r_coef;
        if (start) begin
            r_sr <= '0;
            r_sg <= '0;
            r_sb <= '0;
        end else if (r_v2) begin
            r_sr <= r_sr + SW'(r_pr);
            r_sg <= r_sg + SW'(r_pg);
            r_sb <= r_sb + SW'(r_pb);
        end
        if (r_state == S_SCALE) begin
            r_mr <= MW'($signed(i_cfg.gain)) * MW'(r_sr);
            r_mg <= MW'($signed(i_cfg.gain)) * MW'(r_sg);
            r_mb <= MW'($signed(i_cfg.gain)) * MW'(r_sb);
        end
        if (r_state == S_FIN) begin
            r_out.red_out   <= sat_pix(TW'(r_mr) + bias_q);
            r_out.green_out <= sat_pix(TW'(r_mg) + bias_q);
            r_out.blue_out  <= sat_pix(TW'(r_mb) + bias_q);
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

endmodule

// File: design/rgb_kernel_convolution_unit.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_unit
// RGB square-kernel convolution with clamp-to-edge, gain, bias and saturation.
// ----------------------------------------------------------------------------
// Sequence: after the back end pops a convolve item it walks the ks*ks taps
//   (ks = kernel size; one tap per cycle), drains the MAC pipeline, then scales,
//   finishes and holds the output until taken; with ks zero it skips to scaling.
// Pixel and coefficient writes land in their stores when the back end pops them.
// Reset: synchronous, active low; registers return to their defaults, the
//   queue empties. Frame and coefficient stores are not cleared.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_unit #(
    parameter int MAX_WIDTH  = rkc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rkc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = rkc_pkg::DEF_MAX_KERNEL
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input
    input  logic                       i_valid,
    output logic                       o_stall,
    input  rkc_pkg::t_in_item          i_item,
    // result output
    output logic                       o_valid,
    input  logic                       i_stall,
    output rkc_pkg::t_out_item         o_item,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rkc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    rkc_pkg::t_cfg r_cfg;
    rkc_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          pop;
    logic          wr_en;
    logic [2:0]    reg_idx;

    // --- register file -------------------------------------------------------
    // One register per 32-bit word; writes land on the access phase.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= rkc_pkg::RST_WIDTH;
            r_cfg.height <= rkc_pkg::RST_HEIGHT;
            r_cfg.ksize  <= rkc_pkg::RST_KSIZE;
            r_cfg.gain   <= rkc_pkg::RST_GAIN;
            r_cfg.bias   <= rkc_pkg::RST_BIAS;
        end else if (wr_en) begin
            case (reg_idx)
                rkc_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[7:0];
                rkc_pkg::REG_HEIGHT: r_cfg.height <= pwdata[7:0];
                rkc_pkg::REG_KSIZE:  r_cfg.ksize  <= pwdata[2:0];
                rkc_pkg::REG_GAIN:   r_cfg.gain   <= pwdata[15:0];
                rkc_pkg::REG_BIAS:   r_cfg.bias   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // readback; gain and bias come back zero-extended as written
    always_comb begin
        case (reg_idx)
            rkc_pkg::REG_WIDTH:  prdata = 32'(r_cfg.width);
            rkc_pkg::REG_HEIGHT: prdata = 32'(r_cfg.height);
            rkc_pkg::REG_KSIZE:  prdata = 32'(r_cfg.ksize);
            rkc_pkg::REG_GAIN:   prdata = 32'(r_cfg.gain);
            rkc_pkg::REG_BIAS:   prdata = 32'(r_cfg.bias);
            default:             prdata = 32'd0;
        endcase
    end

    // --- front end: accept, filter no-op items, two-entry queue --------------
    rkc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (pop)
    );

    // --- back end: stores, tap sequencer, MAC, scale and clamp ---------------
    // The result sits in the back end's output register while the front keeps
    // filling its queue.
    rkc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule
